>>> rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Holds the list geometry, the action and status codes and the cell command.
// No dependencies.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STS_W    = 2;
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [STS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  value;
    } ile_cmd_t;

endpackage

>>> rtl/ile_cell.sv
// One storage cell of the list row; holds a single entry.
// Takes the left or right neighbor's entry on insert or remove.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_cell
    import ile_pkg::*;
(
    input  logic                    aclk,
    input  ile_cmd_t                cmd,
    input  logic [IDX_W-1:0]        cell_index,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [VAL_W-1:0] right_value,
    output logic signed [VAL_W-1:0] value,
    output logic signed [VAL_W-1:0] sel_value
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic [POS_W-1:0]        my_pos;

    assign my_pos = POS_W'(cell_index);

    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (my_pos > cmd.pos) begin
                    value_next = left_value;
                end else if (my_pos == cmd.pos) begin
                    value_next = cmd.value;
                end
            end
            OP_REMOVE: begin
                if (my_pos >= cmd.pos) begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign sel_value = (my_pos == cmd.pos) ? value_reg : '0;

endmodule

>>> rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request decode, the row of cells,
// the registered read tree and the result register.
// Depends on ile_pkg and ile_cell.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to 64 signed 32-bit entries in a row of
// cells that all shift together; the result of append, insert, remove and clear
// is valid on the cycle after the request is taken. A get goes through a
// two-level registered OR tree (partial_reg, then the result register); a get
// that is out of bounds answers on the cycle after it is taken. One request is
// in flight at a time: a new one is taken when no get is reading and the result
// register is empty or being drained, so updates go at one request per cycle
// while m_ready stays high, and a get holds the next request until it is done.
module indexed_list_engine
    import ile_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ACT_W-1:0]        s_action,
    input  logic [POS_W-1:0]        s_position,
    input  logic signed [VAL_W-1:0] s_item_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STS_W-1:0]        m_result_status,
    output logic signed [VAL_W-1:0] m_read_value,
    output logic [CNT_W-1:0]        m_entry_count
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                  state_reg;
    logic                    m_valid_reg;
    status_t                 m_status_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic [CNT_W-1:0]        m_count_reg;
    logic [CNT_W-1:0]        fill_count_reg;
    logic [VAL_W-1:0]        partial_reg [NGROUP];

    logic                    accept;
    logic                    full;
    status_t                 status_c;
    logic [CNT_W-1:0]        count_c;
    cell_op_t                op_c;
    logic [POS_W-1:0]        pos_c;
    logic                    get_c;
    ile_cmd_t                cmd;

    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    logic signed [VAL_W-1:0] cell_sel   [CAPACITY];
    logic [VAL_W-1:0]        group_c    [NGROUP];
    logic [VAL_W-1:0]        read_c;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (fill_count_reg == CNT_W'(CAPACITY));

    always_comb begin
        status_c = ST_OK;
        count_c  = fill_count_reg;
        op_c     = OP_HOLD;
        pos_c    = s_position;
        get_c    = 1'b0;
        case (s_action)
            ACT_APPEND: begin
                if (full) begin
                    status_c = ST_FULL;
                end else begin
                    op_c    = OP_INSERT;
                    pos_c   = POS_W'(fill_count_reg);
                    count_c = fill_count_reg + 1'b1;
                end
            end
            ACT_INSERT: begin
                if (s_position > POS_W'(fill_count_reg)) begin
                    status_c = ST_BOUNDS;
                end else if (full) begin
                    status_c = ST_FULL;
                end else begin
                    op_c    = OP_INSERT;
                    count_c = fill_count_reg + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (s_position >= POS_W'(fill_count_reg)) begin
                    status_c = ST_BOUNDS;
                end else begin
                    op_c    = OP_REMOVE;
                    count_c = fill_count_reg - 1'b1;
                end
            end
            ACT_GET: begin
                if (s_position >= POS_W'(fill_count_reg)) begin
                    status_c = ST_BOUNDS;
                end else begin
                    get_c = 1'b1;
                end
            end
            ACT_CLEAR: begin
                count_c = '0;
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb begin
        cmd.op    = accept ? op_c : OP_HOLD;
        cmd.pos   = pos_c;
        cmd.value = s_item_value;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_left
            assign left_value = cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_right
            assign right_value = cell_value[i+1];
        end

        ile_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_index  (IDX_W'(i)),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .sel_value   (cell_sel[i])
        );
    end

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            group_c[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    group_c[g] = group_c[g] | cell_sel[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        read_c = '0;
        for (int g = 0; g < NGROUP; g++) begin
            read_c = read_c | partial_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            fill_count_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        fill_count_reg <= count_c;
                        if (get_c) begin
                            partial_reg <= group_c;
                            state_reg   <= S_READ;
                            m_valid_reg <= 1'b0;
                        end else begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= status_c;
                            m_value_reg  <= '0;
                            m_count_reg  <= count_c;
                        end
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                S_READ: begin
                    m_valid_reg  <= 1'b1;
                    m_status_reg <= ST_OK;
                    m_value_reg  <= read_c;
                    m_count_reg  <= fill_count_reg;
                    state_reg    <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_status = m_status_reg;
    assign m_read_value    = m_value_reg;
    assign m_entry_count   = m_count_reg;

endmodule

>>> rtl/ile_checker.sv
// Port-level checks for the indexed list engine, bound to the top level.
// Depends on ile_pkg and indexed_list_engine.
`timescale 1ns / 1ps

module ile_checker
    import ile_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [STS_W-1:0]        m_result_status,
    input logic signed [VAL_W-1:0] m_read_value,
    input logic [CNT_W-1:0]        m_entry_count
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_status)
            && $stable(m_read_value) && $stable(m_entry_count))
        else $error("stalled result changed");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_failed_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_status != ST_OK) |-> m_read_value == '0)
        else $error("nonzero value on a failed request");

    a_full_means_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_status == ST_FULL) |-> m_entry_count == CNT_W'(CAPACITY))
        else $error("list full reported below capacity");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);
